[design/gdad_pkg.sv]
package gdad_pkg;

    localparam logic [13:0] YEAR_MIN  = 14'd1;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [13:0] CYCLE_400 = 14'd400;
    localparam logic [8:0]  YMOD_LAST = 9'd399;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD_DATE = 2'd1,
        STS_RANGE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_WALK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic reduce;
        logic check;
        logic walk;
    } t_cmd;

    typedef struct packed {
        logic reduce_done;
        logic invalid;
        logic walk_done;
    } t_sts;

    // ymod is the year modulo 400, lo2 the two low bits of the year
    function automatic logic is_leap(input logic [1:0] lo2, input logic [8:0] ymod);
        logic res;
        if (lo2 != 2'd0) begin
            res = 1'b0;
        end else if (ymod == 9'd100 || ymod == 9'd200 || ymod == 9'd300) begin
            res = 1'b0;
        end else begin
            res = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] res;
        case (m)
            4'd2:                      res = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   res = 5'd30;
            default:                   res = 5'd31;
        endcase
        return res;
    endfunction

endpackage

[design/gdad_ctrl.sv]
module gdad_ctrl
    import gdad_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_REDUCE;
            S_REDUCE: if (i_sts.reduce_done) n_state = S_CHECK;
            S_CHECK:  n_state = i_sts.invalid ? S_OUT : S_WALK;
            S_WALK:   if (i_sts.walk_done) n_state = S_OUT;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.load  = i_in_valid;
            end
            S_REDUCE: o_cmd.reduce = 1'b1;
            S_CHECK:  o_cmd.check  = 1'b1;
            S_WALK:   o_cmd.walk   = 1'b1;
            S_OUT:    o_out_valid  = 1'b1;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[design/gdad_dpath.sv]
module gdad_dpath
    import gdad_pkg::*;
(
    input  logic        i_clk,
    input  logic [13:0] i_year_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [16:0] i_day_offset,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [13:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [1:0]  o_status
);

    logic [13:0] r_y0;
    logic [3:0]  r_m0;
    logic [4:0]  r_d0;
    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [16:0] r_n;
    logic        r_back;
    logic [13:0] r_ymod;
    t_status     r_status;

    logic        leap_c;
    logic [4:0]  mlen;
    logic [5:0]  to_next;
    logic        fwd_fin;
    logic        bwd_fin;
    logic        fin;
    logic        range_err;
    logic [3:0]  prev_month;

    assign leap_c     = is_leap(r_year[1:0], r_ymod[8:0]);
    assign mlen       = month_len(leap_c, r_month);
    assign to_next    = {1'b0, mlen} - {1'b0, r_day} + 6'd1;
    assign fwd_fin    = r_n < {11'd0, to_next};
    assign bwd_fin    = r_n < {12'd0, r_day};
    assign fin        = r_back ? bwd_fin : fwd_fin;
    assign range_err  = !fin && (r_back ? (r_month <= MONTH_JAN && r_year <= YEAR_MIN)
                                        : (r_month == MONTH_DEC && r_year == YEAR_MAX));
    assign prev_month = (r_month <= MONTH_JAN) ? MONTH_DEC : r_month - 4'd1;

    assign o_sts.reduce_done = r_ymod < CYCLE_400;
    assign o_sts.invalid     = r_y0 < YEAR_MIN || r_y0 > YEAR_MAX ||
                               r_m0 < MONTH_JAN || r_m0 > MONTH_DEC ||
                               r_d0 == 5'd0 || r_d0 > mlen;
    assign o_sts.walk_done   = fin || range_err;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_y0     <= i_year_in;
            r_m0     <= i_month_in;
            r_d0     <= i_day_in;
            r_year   <= i_year_in;
            r_month  <= i_month_in;
            r_day    <= i_day_in;
            r_ymod   <= i_year_in;
            r_back   <= i_day_offset[16];
            r_n      <= i_day_offset[16] ? (17'd0 - i_day_offset) : i_day_offset;
            r_status <= STS_OK;
        end else if (i_cmd.reduce) begin
            if (!o_sts.reduce_done) begin
                r_ymod <= r_ymod - CYCLE_400;
            end
        end else if (i_cmd.check) begin
            r_status <= o_sts.invalid ? STS_BAD_DATE : STS_OK;
        end else if (i_cmd.walk) begin
            if (range_err) begin
                r_status <= STS_RANGE;
            end else if (fin) begin
                // last partial month
                if (r_back) begin
                    r_day <= r_day - r_n[4:0];
                end else begin
                    r_day <= r_day + r_n[4:0];
                end
                r_n <= '0;
            end else if (!r_back) begin
                r_n   <= r_n - {11'd0, to_next};
                r_day <= 5'd1;
                if (r_month == MONTH_DEC) begin
                    r_month <= MONTH_JAN;
                    r_year  <= r_year + 14'd1;
                    r_ymod  <= (r_ymod[8:0] == YMOD_LAST) ? 14'd0 : r_ymod + 14'd1;
                end else begin
                    r_month <= r_month + 4'd1;
                end
            end else begin
                r_n     <= r_n - {12'd0, r_day};
                r_month <= prev_month;
                // december never depends on the year, so the current year is fine here
                r_day   <= month_len(leap_c, prev_month);
                if (r_month <= MONTH_JAN) begin
                    r_year <= r_year - 14'd1;
                    r_ymod <= (r_ymod == 14'd0) ? {5'd0, YMOD_LAST} : r_ymod - 14'd1;
                end
            end
        end
    end

    assign o_year_out  = (r_status != STS_OK) ? r_y0 : r_year;
    assign o_month_out = (r_status != STS_OK) ? r_m0 : r_month;
    assign o_day_out   = (r_status != STS_OK) ? r_d0 : r_day;
    assign o_status    = r_status;

endmodule

[design/gregorian_date_add_days.sv]
// channel | direction | fields (lowest bit first)
// s_*     | in        | tdata: year_in[13:0], month_in[17:14], day_in[22:18], day_offset[39:23]
// m_*     | out       | tdata: year_out[13:0], month_out[17:14], day_out[22:18], status[24:23]
//
// one item at a time: the item is accepted, the year is reduced modulo 400 by repeated
// subtraction and the date is checked; a bad date skips the walk, else the walk steps one month
// at a time (at most about 2154 months for 65536 days) and ends with the last partial month.
// i_rst_n is synchronous, active low, and returns the controller to idle.
// a result holds on m_* until taken; no new transfer is accepted before then.
module gregorian_date_add_days_core
    import gdad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // year_in, month_in, day_in, day_offset
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // year_out, month_out, day_out, status
);

    t_cmd        cmd;
    t_sts        sts;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [1:0]  status;

    gdad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gdad_dpath u_dpath (
        .i_clk        (i_clk),
        .i_year_in    (i_s_tdata[13:0]),
        .i_month_in   (i_s_tdata[17:14]),
        .i_day_in     (i_s_tdata[22:18]),
        .i_day_offset (i_s_tdata[39:23]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_year_out   (year_out),
        .o_month_out  (month_out),
        .o_day_out    (day_out),
        .o_status     (status)
    );

    assign o_m_tdata = {7'd0, status, day_out, month_out, year_out};

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input and output sides open at once");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready again right after a transfer");

    a_month_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && status == STS_OK) |-> (month_out >= MONTH_JAN && month_out <= MONTH_DEC))
        else $error("month out of range on a good result");

    a_day_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && status == STS_OK) |-> (day_out != 5'd0))
        else $error("zero day on a good result");

endmodule

[verif/gregorian_date_add_days_checker.sv]
module gregorian_date_add_days_checker
    import gdad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // year_in, month_in, day_in, day_offset
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // year_out, month_out, day_out, status
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        t_status     status;
    } t_shifted_date;

    t_shifted_date dates_due[$];
    int            fail_total    = 0;
    int            results_taken = 0;

    assign o_fail_count = fail_total;

    function automatic logic leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            2:             len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    // month-by-month walk, forward or backward by the offset's magnitude
    function automatic t_shifted_date shift_date(input logic [39:0] word);
        t_shifted_date res;
        int unsigned   y0, m0, d0, y, m, d, left, step;
        logic [16:0]   off, mag;
        logic          back;
        y0   = 32'(word[13:0]);
        m0   = 32'(word[17:14]);
        d0   = 32'(word[22:18]);
        off  = word[39:23];
        back = off[16];
        mag  = -off;
        left = 32'(back ? mag : off);
        y = y0;
        m = m0;
        d = d0;
        res.status = STS_OK;
        if (y0 < YEAR_MIN || y0 > YEAR_MAX || m0 < MONTH_JAN || m0 > MONTH_DEC ||
            d0 < 1 || d0 > days_in_month(y0, m0)) begin
            res.status = STS_BAD_DATE;
        end else if (!back) begin
            while (left > 0) begin
                step = days_in_month(y, m) - d + 1;
                if (left < step) begin
                    d    = d + left;
                    left = 0;
                end else begin
                    left = left - step;
                    m    = m + 1;
                    if (m > MONTH_DEC) begin
                        m = 32'(MONTH_JAN);
                        y = y + 1;
                        if (y > YEAR_MAX) begin
                            res.status = STS_RANGE;
                            left       = 0;
                        end
                    end
                    d = 1;
                end
            end
        end else begin
            while (left > 0) begin
                if (left < d) begin
                    d    = d - left;
                    left = 0;
                end else begin
                    left = left - d;
                    if (m <= MONTH_JAN) begin
                        m = 32'(MONTH_DEC);
                        if (y <= YEAR_MIN) begin
                            res.status = STS_RANGE;
                            left       = 0;
                        end else begin
                            y = y - 1;
                        end
                    end else begin
                        m = m - 1;
                    end
                    d = days_in_month(y, m);
                end
            end
        end
        if (res.status != STS_OK) begin
            y = y0;
            m = m0;
            d = d0;
        end
        res.year  = 14'(y);
        res.month = 4'(m);
        res.day   = 5'(d);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: result %0d %s: got %0d, want %0d", $realtime, results_taken, what,
                 got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : watch
        t_shifted_date want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                dates_due.push_back(shift_date(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (dates_due.size() == 0) begin
                    report_mismatch("arrived with nothing due", i_m_tdata, 0);
                end else begin
                    want = dates_due.pop_front();
                    if (i_m_tdata[13:0] != want.year)
                        report_mismatch("year", int'(i_m_tdata[13:0]), int'(want.year));
                    if (i_m_tdata[17:14] != want.month)
                        report_mismatch("month", int'(i_m_tdata[17:14]), int'(want.month));
                    if (i_m_tdata[22:18] != want.day)
                        report_mismatch("day", int'(i_m_tdata[22:18]), int'(want.day));
                    if (i_m_tdata[24:23] != want.status)
                        report_mismatch("status", int'(i_m_tdata[24:23]), int'(want.status));
                    if (i_m_tdata[31:25] != '0)
                        report_mismatch("padding", int'(i_m_tdata[31:25]), 0);
                end
                results_taken++;
            end
        end
        o_pending <= dates_due.size();
    end

endmodule

[verif/gregorian_date_add_days_core_tb.sv]
module gregorian_date_add_days_core_tb;

    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 2500;
    localparam int LONG_HOLD    = 4000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending;

    int          burst_left = 0;
    logic        quiet      = 1'b0;
    int          hold_asks  = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    int          run_left   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gregorian_date_add_days_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    gregorian_date_add_days_checker date_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: ready and stall runs, a long hold on request, ready when quiet and no hold runs
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            run_left <= 0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (run_left > 0) begin
            run_left <= run_left - 1;
        end else begin
            m_tready <= !m_tready;
            if (m_tready) begin
                run_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 6);
            end else begin
                run_left <= $urandom_range(0, 25);
            end
        end
    end

    function automatic logic [39:0] pack_item(input int y, input int m, input int d,
                                              input int off);
        logic [13:0] yv;
        logic [3:0]  mv;
        logic [4:0]  dv;
        logic [16:0] ov;
        yv = 14'(y);
        mv = 4'(m);
        dv = 5'(d);
        ov = 17'(off);
        return {ov, dv, mv, yv};
    endfunction

    function automatic logic [39:0] random_item();
        logic [39:0] word;
        int          y, m, d, mag, off, pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // raw noise, mostly bad dates
            word[31:0]  = $urandom;
            word[39:32] = 8'($urandom);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                y = $urandom_range(1, 3);
            else if (pick == 1)
                y = $urandom_range(9997, 9999);
            else if (pick < 6)
                y = $urandom_range(1580, 2420);
            else
                y = $urandom_range(1, 9999);
            m = $urandom_range(1, 12);
            // days past the 28th now and then overrun the month
            d = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 28) : $urandom_range(29, 31);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                mag = $urandom_range(40000, 65536);
            else if (pick < 15)
                mag = $urandom_range(0, 20000);
            else if (pick < 85)
                mag = $urandom_range(0, 1500);
            else
                mag = $urandom_range(0, 62);
            off  = $urandom_range(0, 1) ? -mag : mag;
            word = pack_item(y, m, d, off);
        end
        return word;
    endfunction

    task automatic send_item(input logic [39:0] word);
        int gap;
        if (burst_left == 0 && !quiet) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        int i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(pack_item(1, 1, 1, 0));
        send_item(pack_item(9999, 12, 31, 0));
        send_item(pack_item(9999, 12, 31, 1));        // past the last day
        send_item(pack_item(1, 1, 1, -1));            // before the first day
        send_item(pack_item(1, 1, 1, 65535));
        send_item(pack_item(9999, 12, 31, -65536));   // most negative pattern
        send_item(pack_item(9999, 12, 31, -65535));
        send_item(pack_item(2000, 2, 28, 1));         // leap by the 400 rule
        send_item(pack_item(1900, 2, 28, 1));         // century, no leap
        send_item(pack_item(2100, 2, 29, 0));         // bad date, no leap
        send_item(pack_item(2024, 2, 29, 365));
        send_item(pack_item(2024, 3, 1, -1));
        send_item(pack_item(2023, 12, 31, 1));
        send_item(pack_item(2024, 3, 5, -5));         // back by exactly the day
        send_item(pack_item(2024, 1, 31, -31));
        send_item(pack_item(0, 6, 15, 10));
        send_item(pack_item(16383, 1, 1, 0));
        send_item(pack_item(10000, 1, 1, 5));
        send_item(pack_item(2020, 0, 10, 3));
        send_item(pack_item(2020, 13, 10, 3));
        send_item(pack_item(2020, 15, 31, -1));
        send_item(pack_item(2020, 4, 31, 1));
        send_item(pack_item(2020, 7, 0, 1));
        send_item(pack_item(9998, 1, 1, 730));
        send_item(pack_item(1, 12, 31, -365));
        wait_drained();

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 300) hold_asks <= hold_asks + 1;
            if (i == 600 || i == 1500) wait_drained();
            if (i == 900) quiet <= 1'b1;
            if (i == 1100) quiet <= 1'b0;
            send_item(random_item());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS gregorian_date_add_days_core");
        end else begin
            $display("FAIL gregorian_date_add_days_core");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("FAIL gregorian_date_add_days_core");
        $finish;
    end

endmodule

[files.f]
design/gdad_pkg.sv
design/gdad_ctrl.sv
design/gdad_dpath.sv
design/gregorian_date_add_days.sv
verif/gregorian_date_add_days_checker.sv
verif/gregorian_date_add_days_core_tb.sv
